/* rtl/drtm_pkg.sv */
// ----------------------------------------------------------------------------
// drtm_pkg: shared types and constants for the descriptor ratio-test matcher
// Request codes, widths, distance limit, ratio reset and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package drtm_pkg;
	localparam int DIST_W = 23;
	localparam logic [DIST_W-1:0] DIST_MAX = 23'h7FFFFF;
	localparam int COORD_W = 12;
	localparam int RATIO_W = 17;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd41943;

	typedef enum logic [1:0] {
		REQ_REF   = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;
endpackage
`default_nettype wire

/* rtl/drtm_sqdiff.sv */
// ----------------------------------------------------------------------------
// drtm_sqdiff: squared difference of two elements, registered
// One 8x8 multiply per cycle feeding the distance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module drtm_sqdiff (
	input  wire logic        clk,
	input  wire logic [7:0]  a,
	input  wire logic [7:0]  b,
	output logic      [15:0] sq
);
	logic [7:0] diff;

	// absolute difference then square
	assign diff = (a > b) ? (a - b) : (b - a);

	always_ff @(posedge clk) begin
		sq <= 16'(diff) * 16'(diff);
	end
endmodule
`default_nettype wire

/* rtl/descriptor_ratio_test_matcher.sv */
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher: nearest-neighbor ratio-test matcher
// Stores reference descriptors in one memory and scans them per query.
// ----------------------------------------------------------------------------
// Channel   | Signals                                              | Dir
// request   | start, busy, req_type, element_value, last_element, | in (busy: out)
//           | point_col, point_row                                 |
// config    | ratio_we, ratio_sq_q16                               | in
// result    | done, matched, too_few_refs, query_col, query_row,  | out
//           | ref_col, ref_row, best_dist_sq                       |
// Element words are accepted only while idle; a descriptor that ends
// before DESC_LEN words stays busy while its tail is zeroed. A
// completed query then scans every stored reference (one element per
// cycle from the single read port), drains the read pipeline and
// reports, reading nothing with no references; done is registered
// from the report state. Reset clears the control state; memories are
// never cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module descriptor_ratio_test_matcher #(
	parameter int DESC_LEN = 128,
	parameter int REF_MAX  = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   req_type,
	input  wire logic [7:0]                   element_value,
	input  wire logic                         last_element,
	input  wire logic [drtm_pkg::COORD_W-1:0] point_col,
	input  wire logic [drtm_pkg::COORD_W-1:0] point_row,
	input  wire logic                         ratio_we,
	input  wire logic [drtm_pkg::RATIO_W-1:0] ratio_sq_q16,
	output logic                              done,
	output logic                              matched,
	output logic                              too_few_refs,
	output logic      [drtm_pkg::COORD_W-1:0] query_col,
	output logic      [drtm_pkg::COORD_W-1:0] query_row,
	output logic      [drtm_pkg::COORD_W-1:0] ref_col,
	output logic      [drtm_pkg::COORD_W-1:0] ref_row,
	output logic      [drtm_pkg::DIST_W-1:0]  best_dist_sq
);
	import drtm_pkg::*;

	localparam int EW = $clog2(DESC_LEN);
	localparam int RW = $clog2(REF_MAX);
	localparam int CW = $clog2(REF_MAX + 1);
	localparam int AW = RW + EW;
	localparam int ACC_W = 16 + EW + 1;

	// memories
	logic [7:0]           ref_mem [1 << AW];
	logic [2*COORD_W-1:0] coord_mem [REF_MAX];
	logic [7:0]           qry_mem [DESC_LEN];

	state_t state_q, state_d;
	logic [RATIO_W-1:0] ratio_q;
	logic [CW-1:0]  ref_count_q;
	logic [EW-1:0]  elem_q;
	logic           kind_q;           // 1 = query
	logic [EW-1:0]  fill_q;           // tail zeroing index
	logic           fill_ok_q;
	logic [RW-1:0]  fill_slot_q;
	logic [CW-1:0]  scan_ref_q;
	logic [EW-1:0]  scan_el_q;
	logic           rd_v_s1, rd_v_s2;
	logic           rd_last_s1, rd_last_s2;
	logic [7:0]     rd_ref_s1, rd_qry_s1;
	logic [ACC_W-1:0] acc_q;
	logic [CW-1:0]  acc_ref_q;
	logic [DIST_W-1:0] best_q, second_q;
	logic [RW-1:0]  best_idx_q;
	logic [COORD_W-1:0] qcol_q, qrow_q;
	logic [15:0]    sq_s2;
	logic [2*COORD_W-1:0] coord_rd_q;

	logic accept;
	logic cur_kind;
	logic cur_ok;
	logic [RW-1:0] cur_slot;
	logic desc_end;
	logic [ACC_W-1:0] acc_sum;
	logic [DIST_W-1:0] ref_dist;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cur_kind = (elem_q == '0) ? (req_type == REQ_QUERY) : kind_q;
	assign cur_ok   = cur_kind || (ref_count_q < CW'(REF_MAX));
	assign cur_slot = (ref_count_q < CW'(REF_MAX)) ? ref_count_q[RW-1:0] : '0;
	assign desc_end = last_element || (elem_q == EW'(DESC_LEN - 1));

	// ratio register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (ratio_we) begin
			ratio_q <= ratio_sq_q16;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_REF || req_type == REQ_QUERY) && desc_end) begin
					if (elem_q != EW'(DESC_LEN - 1)) state_d = ST_FILL;
					else if (cur_kind) state_d = ST_SCAN;
				end
			end
			ST_FILL: begin
				if (fill_q == EW'(DESC_LEN - 1)) state_d = kind_q ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (ref_count_q == '0 ||
				    (scan_ref_q == ref_count_q - 1'b1 && scan_el_q == EW'(DESC_LEN - 1)))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !rd_v_s2 && acc_ref_q == ref_count_q) state_d = ST_RESULT;
				if (ref_count_q == '0) state_d = ST_RESULT;
			end
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// descriptor intake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= '0;
			elem_q      <= '0;
			kind_q      <= 1'b0;
			fill_q      <= '0;
			fill_ok_q   <= 1'b0;
			fill_slot_q <= '0;
		end else if (accept) begin
			if (req_type == REQ_CLEAR) begin
				ref_count_q <= '0;
				elem_q      <= '0;
			end else if (req_type != REQ_NONE) begin
				kind_q      <= cur_kind;
				fill_ok_q   <= cur_ok;
				fill_slot_q <= cur_slot;
				fill_q      <= elem_q + 1'b1;
				if (desc_end) begin
					elem_q <= '0;
					if (!cur_kind && ref_count_q < CW'(REF_MAX))
						ref_count_q <= ref_count_q + 1'b1;
				end else begin
					elem_q <= elem_q + 1'b1;
				end
			end
		end else if (state_q == ST_FILL) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// memory writes: element words, coordinates and tail zeroing
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_REF || req_type == REQ_QUERY) && cur_ok) begin
			if (cur_kind) qry_mem[elem_q] <= element_value;
			else          ref_mem[{cur_slot, elem_q}] <= element_value;
			if (desc_end) begin
				if (cur_kind) begin
					qcol_q <= point_col;
					qrow_q <= point_row;
				end else begin
					coord_mem[cur_slot] <= {point_row, point_col};
				end
			end
		end else if (state_q == ST_FILL && fill_ok_q) begin
			if (kind_q) qry_mem[fill_q] <= 8'd0;
			else        ref_mem[{fill_slot_q, fill_q}] <= 8'd0;
		end
	end

	// scan address walk and registered reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ref_q <= '0;
			scan_el_q  <= '0;
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_v_s1    <= (state_q == ST_SCAN) && (ref_count_q != '0);
			rd_last_s1 <= scan_el_q == EW'(DESC_LEN - 1);
			if (state_q == ST_SCAN) begin
				scan_el_q <= scan_el_q + 1'b1;
				if (scan_el_q == EW'(DESC_LEN - 1)) scan_ref_q <= scan_ref_q + 1'b1;
			end else begin
				scan_ref_q <= '0;
				scan_el_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ref_s1 <= ref_mem[AW'({scan_ref_q[RW-1:0], scan_el_q})];
		rd_qry_s1 <= qry_mem[scan_el_q];
		coord_rd_q <= coord_mem[best_idx_q];
	end

	drtm_sqdiff u_sqdiff (
		.clk (clk),
		.a   (rd_qry_s1),
		.b   (rd_ref_s1),
		.sq  (sq_s2)
	);

	// accumulate and keep the two smallest distances
	assign acc_sum  = acc_q + ACC_W'(sq_s2);
	assign ref_dist = (acc_sum > ACC_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s2    <= 1'b0;
			rd_last_s2 <= 1'b0;
			acc_q      <= '0;
			acc_ref_q  <= '0;
			best_q     <= DIST_MAX;
			second_q   <= DIST_MAX;
			best_idx_q <= '0;
		end else begin
			rd_v_s2    <= rd_v_s1;
			rd_last_s2 <= rd_last_s1;
			if (state_q == ST_IDLE) begin
				acc_q      <= '0;
				acc_ref_q  <= '0;
				best_q     <= DIST_MAX;
				second_q   <= DIST_MAX;
				best_idx_q <= '0;
			end else if (rd_v_s2) begin
				if (rd_last_s2) begin
					acc_q     <= '0;
					acc_ref_q <= acc_ref_q + 1'b1;
					if (ref_dist < best_q) begin
						second_q   <= best_q;
						best_q     <= ref_dist;
						best_idx_q <= acc_ref_q[RW-1:0];
					end else if (ref_dist < second_q) begin
						second_q <= ref_dist;
					end
				end else begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	// result word
	logic few;
	logic [DIST_W+16:0] lhs;
	logic [DIST_W+RATIO_W-1:0] rhs;
	assign few = ref_count_q < CW'(2);
	assign lhs = {1'b0, best_q, 16'd0};
	assign rhs = {{DIST_W{1'b0}}, ratio_q} * {{RATIO_W{1'b0}}, second_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= (state_q == ST_RESULT);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT) begin
			matched      <= !few && second_q != '0 && (lhs <= (DIST_W+17)'(rhs));
			too_few_refs <= few;
			query_col    <= qcol_q;
			query_row    <= qrow_q;
			ref_col      <= (ref_count_q == '0) ? '0 : coord_rd_q[COORD_W-1:0];
			ref_row      <= (ref_count_q == '0) ? '0 : coord_rd_q[2*COORD_W-1:COORD_W];
			best_dist_sq <= (ref_count_q == '0) ? '0 : best_q;
		end
	end
endmodule
`default_nettype wire

/* rtl/drtm_checker.sv */
// ----------------------------------------------------------------------------
// drtm_checker: port-level checks for the matcher
// Watches the handshake and result strobes over time.
// ----------------------------------------------------------------------------
`default_nettype none
module drtm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic matched,
	input wire logic too_few_refs
);
	// a result word is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// a match never comes with too few references
	a_match_refs: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(matched && too_few_refs)) else $error("match with few refs");
	// results appear only after the engine was busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	// engine idle while a result is shown
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy at result");
endmodule

bind descriptor_ratio_test_matcher drtm_checker u_drtm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.matched      (matched),
	.too_few_refs (too_few_refs)
);
`default_nettype wire

/* verif/descriptor_ratio_test_matcher_tb.sv */
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher_tb: self-checking bench for the ratio matcher
// Streams reference and query descriptors with random content and gaps. A
// scoreboard recomputes nearest/second-nearest distances and the ratio test
// per query and checks each result word, field by field, in order.
// ----------------------------------------------------------------------------
module descriptor_ratio_test_matcher_tb;
	import drtm_pkg::*;

	localparam int DESC_LEN   = 128;
	localparam int REF_MAX    = 256;
	localparam int WORDS      = 1100;
	localparam int IDLE_LIMIT = 100000;
	localparam int SETTLE     = 300;

	typedef struct packed {
		logic               matched;
		logic               too_few;
		logic [COORD_W-1:0] q_col;
		logic [COORD_W-1:0] q_row;
		logic [COORD_W-1:0] r_col;
		logic [COORD_W-1:0] r_row;
		logic [DIST_W-1:0]  dist_sq;
	} match_t;

	// Scoreboard: mirrors the matcher state and queues expected match words
	class match_scoreboard;
		logic [7:0]         ref_mem [REF_MAX*DESC_LEN];
		logic [2*COORD_W-1:0] ref_pos [REF_MAX];
		logic [7:0]         query_mem [DESC_LEN];
		int                 n_refs;
		int                 elem;
		logic [1:0]         kind;
		logic [RATIO_W-1:0] ratio;
		match_t             pending_q [$];
		int                 errors;

		function new();
			n_refs = 0;
			elem = 0;
			kind = REQ_REF;
			ratio = RATIO_RESET;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// Sum of squared differences against one stored reference, saturated
		function logic [DIST_W-1:0] ssd(int r);
			longint acc;
			int d;
			acc = 0;
			for (int i = 0; i < DESC_LEN; i++) begin
				d = int'(query_mem[i]) - int'(ref_mem[r*DESC_LEN+i]);
				acc += d * d;
			end
			return (acc > longint'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
		endfunction

		// Accepted request word
		function void note_word(logic [1:0] t, logic [7:0] v, logic last,
				logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			logic slot_ok;
			logic [DIST_W-1:0] best, second, d;
			int best_idx;
			match_t m;
			if (t == REQ_CLEAR) begin
				n_refs = 0;
				elem = 0;
				return;
			end
			if (t == REQ_NONE)
				return;
			if (elem == 0)
				kind = t;
			slot_ok = (kind == REQ_QUERY) || (n_refs < REF_MAX);
			if (slot_ok) begin
				if (kind == REQ_REF)
					ref_mem[n_refs*DESC_LEN+elem] = v;
				else
					query_mem[elem] = v;
			end
			if (!last && elem < DESC_LEN-1) begin
				elem++;
				return;
			end
			// descriptor ends: unsupplied tail reads as zero
			if (slot_ok) begin
				for (int k = elem+1; k < DESC_LEN; k++) begin
					if (kind == REQ_REF)
						ref_mem[n_refs*DESC_LEN+k] = 8'd0;
					else
						query_mem[k] = 8'd0;
				end
			end
			elem = 0;
			if (kind == REQ_REF) begin
				if (n_refs < REF_MAX) begin
					ref_pos[n_refs] = {row, col};
					n_refs++;
				end
				return;
			end
			// query complete: nearest and second nearest
			best = DIST_MAX;
			second = DIST_MAX;
			best_idx = 0;
			for (int k = 0; k < n_refs; k++) begin
				d = ssd(k);
				if (d < best) begin
					second = best;
					best = d;
					best_idx = k;
				end else if (d < second) begin
					second = d;
				end
			end
			m = '0;
			m.too_few = (n_refs < 2);
			m.q_col = col;
			m.q_row = row;
			if (n_refs > 0) begin
				m.r_col = ref_pos[best_idx][COORD_W-1:0];
				m.r_row = ref_pos[best_idx][2*COORD_W-1:COORD_W];
				m.dist_sq = best;
			end
			if (!m.too_few && second != 0)
				m.matched = (longint'(best) * 65536) <= (longint'(ratio) * longint'(second));
			pending_q = {pending_q, m};
		endfunction

		// Result word from the matcher
		task check_result(match_t got);
			match_t exp;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result word %h", got));
				return;
			end
			exp = pending_q.pop_front();
			if (got.matched !== exp.matched)
				report($sformatf("matched %b exp %b", got.matched, exp.matched));
			if (got.too_few !== exp.too_few)
				report($sformatf("too_few_refs %b exp %b", got.too_few, exp.too_few));
			if (got.q_col !== exp.q_col)
				report($sformatf("query_col %0d exp %0d", got.q_col, exp.q_col));
			if (got.q_row !== exp.q_row)
				report($sformatf("query_row %0d exp %0d", got.q_row, exp.q_row));
			if (got.r_col !== exp.r_col)
				report($sformatf("ref_col %0d exp %0d", got.r_col, exp.r_col));
			if (got.r_row !== exp.r_row)
				report($sformatf("ref_row %0d exp %0d", got.r_row, exp.r_row));
			if (got.dist_sq !== exp.dist_sq)
				report($sformatf("best_dist_sq %0d exp %0d", got.dist_sq, exp.dist_sq));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic [7:0]         element_value;
	logic               last_element;
	logic [COORD_W-1:0] point_col;
	logic [COORD_W-1:0] point_row;
	logic               ratio_we;
	logic [RATIO_W-1:0] ratio_sq_q16;
	logic               done;
	logic               matched;
	logic               too_few_refs;
	logic [COORD_W-1:0] query_col;
	logic [COORD_W-1:0] query_row;
	logic [COORD_W-1:0] ref_col;
	logic [COORD_W-1:0] ref_row;
	logic [DIST_W-1:0]  best_dist_sq;

	match_scoreboard sb;
	int words_sent;
	int idle_cycles;
	bit gaps_on;

	descriptor_ratio_test_matcher #(.DESC_LEN(DESC_LEN), .REF_MAX(REF_MAX)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .element_value(element_value),
		.last_element(last_element), .point_col(point_col), .point_row(point_row),
		.ratio_we(ratio_we), .ratio_sq_q16(ratio_sq_q16),
		.done(done), .matched(matched), .too_few_refs(too_few_refs),
		.query_col(query_col), .query_row(query_row),
		.ref_col(ref_col), .ref_row(ref_row), .best_dist_sq(best_dist_sq)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Result monitor and no-progress watchdog
	always @(posedge clk) begin
		if (done)
			sb.check_result({matched, too_few_refs, query_col, query_row,
				ref_col, ref_row, best_dist_sq});
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no progress");
			$display("FAIL");
			$finish;
		end
	end

	// One request word: hold until accepted, then an optional gap
	task send_word(logic [1:0] t, logic [7:0] v, logic last,
			logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
		int gap;
		start <= 1'b1;
		req_type <= t;
		element_value <= v;
		last_element <= last;
		point_col <= col;
		point_row <= row;
		do
			@(posedge clk);
		while (busy);
		sb.note_word(t, v, last, col, row);
		if (t != REQ_NONE)
			words_sent++;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function logic [7:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Descriptor of len words; a full-length one may end without the last flag
	task send_desc(logic [1:0] t, int len, bit mark_last);
		for (int i = 0; i < len; i++)
			send_word(t, rand_elem(), (i == len-1) && (len < DESC_LEN || mark_last),
				12'($urandom), 12'($urandom));
	endtask

	// Wait until every match word is back, then let tail zeroing finish
	task drain();
		start <= 1'b0;
		while (sb.pending_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_ratio(logic [RATIO_W-1:0] val);
		ratio_we <= 1'b1;
		ratio_sq_q16 <= val;
		@(posedge clk);
		sb.ratio = val;
		ratio_we <= 1'b0;
	endtask

	function int pick_len();
		if ($urandom_range(0, 19) == 0)
			return DESC_LEN;
		return $urandom_range(1, 8);
	endfunction

	initial begin
		int n;
		sb = new();
		words_sent = 0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_NONE;
		element_value = '0;
		last_element = 1'b0;
		point_col = '0;
		point_row = '0;
		ratio_we = 1'b0;
		ratio_sq_q16 = RATIO_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty set, single reference, zero second distance
		send_word(REQ_QUERY, 8'd255, 1'b1, 12'd4095, 12'd0);
		send_word(REQ_REF, 8'd0, 1'b1, 12'd0, 12'd4095);
		send_word(REQ_QUERY, 8'd255, 1'b1, 12'd0, 12'd4095);
		send_word(REQ_REF, 8'd0, 1'b1, 12'd4095, 12'd4095);
		send_word(REQ_QUERY, 8'd0, 1'b1, 12'd1, 12'd2);
		send_word(REQ_QUERY, 8'd255, 1'b1, 12'd4095, 12'd4095);
		// unused type ignored, then clear empties the set
		send_word(REQ_NONE, 8'd77, 1'b1, 12'd5, 12'd5);
		send_word(REQ_CLEAR, 8'd0, 1'b0, 12'd0, 12'd0);
		send_word(REQ_QUERY, 8'd9, 1'b1, 12'd3, 12'd4);
		// type latched at the first word of a descriptor
		send_word(REQ_REF, 8'd10, 1'b0, 12'd0, 12'd0);
		send_word(REQ_QUERY, 8'd20, 1'b1, 12'd100, 12'd200);
		send_word(REQ_QUERY, 8'd12, 1'b0, 12'd0, 12'd0);
		send_word(REQ_REF, 8'd22, 1'b1, 12'd300, 12'd400);
		send_word(REQ_REF, 8'd200, 1'b1, 12'd7, 12'd8);
		// clear aborts a partial descriptor
		send_word(REQ_REF, 8'd1, 1'b0, 12'd0, 12'd0);
		send_word(REQ_CLEAR, 8'd0, 1'b0, 12'd0, 12'd0);
		send_word(REQ_REF, 8'd30, 1'b1, 12'd11, 12'd12);
		send_word(REQ_REF, 8'd60, 1'b1, 12'd13, 12'd14);
		send_word(REQ_QUERY, 8'd40, 1'b1, 12'd15, 12'd16);
		drain();

		// Random phases, register rewritten between them while idle
		for (int phase = 0; words_sent < WORDS; phase++) begin
			case (phase % 5)
				0: write_ratio(17'd0);
				1: write_ratio(17'd65536);
				2: write_ratio(17'h1FFFF);
				3: write_ratio(RATIO_RESET);
				default: write_ratio(17'($urandom_range(0, 65536)));
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			if (phase == 3) begin
				// overflow: more references than the store holds
				send_word(REQ_CLEAR, 8'd0, 1'b0, 12'd0, 12'd0);
				for (int r = 0; r < REF_MAX + 3; r++)
					send_desc(REQ_REF, 1, 1'b1);
				send_desc(REQ_QUERY, 2, 1'b1);
				drain();
				continue;
			end
			if ($urandom_range(0, 2) == 0)
				send_word(REQ_CLEAR, 8'd0, 1'b0, 12'd0, 12'd0);
			n = $urandom_range(0, 5);
			for (int r = 0; r < n; r++)
				send_desc(REQ_REF, pick_len(), $urandom_range(0, 1));
			// noise and broken descriptors
			if ($urandom_range(0, 4) == 0)
				send_word(REQ_NONE, rand_elem(), 1'($urandom), 12'($urandom), 12'($urandom));
			if ($urandom_range(0, 6) == 0) begin
				send_desc(REQ_REF, 1 + $urandom_range(0, 3), 1'b0);
				send_word(REQ_QUERY, rand_elem(), 1'b1, 12'($urandom), 12'($urandom));
			end
			n = $urandom_range(1, 3);
			for (int q = 0; q < n; q++)
				send_desc(REQ_QUERY, pick_len(), $urandom_range(0, 1));
			drain();
		end

		drain();
		while (sb.pending_q.size() > 0) begin
			void'(sb.pending_q.pop_front());
			sb.report("expected result word never arrived");
		end
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* sim.f */
rtl/drtm_pkg.sv
rtl/drtm_sqdiff.sv
rtl/descriptor_ratio_test_matcher.sv
rtl/drtm_checker.sv
verif/descriptor_ratio_test_matcher_tb.sv
